// ----- rtl/core/lesq_pkg.sv -----
// shared types and constants for the largest empty square scan
package lesq_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int SIZE_W   = 11;
    localparam int CHAR_W   = 8;
    localparam int CFG_W    = 11;
    localparam int IDX_W    = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [IDX_W-1:0] REG_OBSTACLE_CODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROW_WIDTH     = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROW_COUNT     = 2'd2;

    localparam logic [CFG_W-1:0] MAX_COLS_V = CFG_W'(MAX_COLS);
    localparam logic [CFG_W-1:0] MAX_ROWS_V = CFG_W'(MAX_ROWS);

    typedef struct packed {
        logic [CHAR_W-1:0] obstacle_code;
        logic [CFG_W-1:0]  row_width;
        logic [CFG_W-1:0]  row_count;
    } t_cfg;

    typedef struct packed {
        logic             free;
        logic             edge_cell;
        logic             end_of_row;
        logic             end_of_map;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_item;

    function automatic logic [CFG_W-1:0] limit_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] top);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > top) begin
            r = top;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/lesq_front.sv -----
// front end: accepts map cells, tracks position and classifies each cell
module lesq_front
    import lesq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_cell_char,
    input  logic              i_queue_full,
    output logic              o_push,
    output t_item             o_item
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CFG_W-1:0] width_lim;
    logic [CFG_W-1:0] rows_lim;
    logic             last_col;
    logic             last_row;
    logic             take;

    assign width_lim = limit_size(i_cfg.row_width, MAX_COLS_V);
    assign rows_lim  = limit_size(i_cfg.row_count, MAX_ROWS_V);
    assign last_col  = ({1'b0, r_col} + CFG_W'(1)) >= width_lim;
    assign last_row  = ({1'b0, r_row} + CFG_W'(1)) >= rows_lim;

    assign o_ready = !i_queue_full;
    assign take    = i_valid && o_ready;
    assign o_push  = take;

    always_comb begin
        o_item.free       = i_cell_char != i_cfg.obstacle_code;
        o_item.edge_cell  = (r_row == '0) || (r_col == '0);
        o_item.end_of_row = last_col;
        o_item.end_of_map = last_col && last_row;
        o_item.row        = r_row;
        o_item.col        = r_col;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (take) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ----- rtl/core/lesq_queue.sv -----
// short request queue between the front end and the score unit
module lesq_queue
    import lesq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_nonempty,
    output t_item o_head
);

    t_item             r_store [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full     = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_head     = r_store[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// ----- rtl/core/lesq_back.sv -----
// score unit: line buffer, square scores, best tracking and result register
module lesq_back
    import lesq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic              i_nonempty,
    input  t_item             i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SIZE_W-1:0] o_square_size,
    output logic [ROW_W-1:0]  o_bottom_row,
    output logic [COL_W-1:0]  o_right_col
);

    logic [SIZE_W-1:0] r_line [MAX_COLS];
    logic [SIZE_W-1:0] r_top;
    t_item             r_cur;
    logic              r_cur_valid;
    logic [SIZE_W-1:0] r_left;
    logic [SIZE_W-1:0] r_diag;
    logic [SIZE_W-1:0] r_best_size;
    logic [ROW_W-1:0]  r_best_row;
    logic [COL_W-1:0]  r_best_col;
    logic              r_out_valid;
    logic [SIZE_W-1:0] r_out_size;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;

    logic [SIZE_W-1:0] min_tl;
    logic [SIZE_W-1:0] min3;
    logic [SIZE_W-1:0] score;
    logic              better;
    logic [SIZE_W-1:0] n_best_size;
    logic [ROW_W-1:0]  n_best_row;
    logic [COL_W-1:0]  n_best_col;
    logic              fire;

    assign fire  = r_cur_valid && (!r_cur.end_of_map || !r_out_valid || i_ready);
    assign o_pop = i_nonempty && (!r_cur_valid || fire);

    assign min_tl = (r_top < r_left) ? r_top : r_left;
    assign min3   = (min_tl < r_diag) ? min_tl : r_diag;

    always_comb begin
        if (!r_cur.free) begin
            score = '0;
        end else if (r_cur.edge_cell) begin
            score = SIZE_W'(1);
        end else begin
            score = min3 + SIZE_W'(1);
        end
    end

    assign better      = score > r_best_size;
    assign n_best_size = better ? score : r_best_size;
    assign n_best_row  = better ? r_cur.row : r_best_row;
    assign n_best_col  = better ? r_cur.col : r_best_col;

    // line buffer
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_line[r_cur.col] <= score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_top <= r_line[i_head.col];
            r_cur <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
        end else if (o_pop) begin
            r_cur_valid <= 1'b1;
        end else if (fire) begin
            r_cur_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else if (fire) begin
            if (r_cur.end_of_row) begin
                r_left <= '0;
                r_diag <= '0;
            end else begin
                r_left <= score;
                r_diag <= r_top;
            end
            if (r_cur.end_of_map) begin
                r_best_size <= '0;
                r_best_row  <= '0;
                r_best_col  <= '0;
            end else begin
                r_best_size <= n_best_size;
                r_best_row  <= n_best_row;
                r_best_col  <= n_best_col;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_cur.end_of_map) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_cur.end_of_map) begin
            r_out_size <= n_best_size;
            r_out_row  <= n_best_row;
            r_out_col  <= n_best_col;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_square_size = r_out_size;
    assign o_bottom_row  = r_out_row;
    assign o_right_col   = r_out_col;

endmodule

// ----- rtl/core/largest_empty_square_scan.sv -----
// top level of the largest empty square scan
//
// channel  direction  handshake            payload
// cells    in         i_valid / o_ready    i_cell_char
// result   out        o_valid / i_ready    o_square_size, o_bottom_row, o_right_col
// config   in         i_cfg_we             i_cfg_index, i_cfg_data
//
// one cell per cycle sustained while the queue has room, set by one line buffer read and write per cell
// each cell is queued, then registered and scored; the result follows the last cell
// reset clears position, scores and best; the line buffer is not cleared
// a waiting result stalls only the last cell of the next map; a 4-entry queue
// lets the front keep taking cells while the score unit stalls
module largest_empty_square_scan
    import lesq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_cell_char,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SIZE_W-1:0] o_square_size,
    output logic [ROW_W-1:0]  o_bottom_row,
    output logic [COL_W-1:0]  o_right_col,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cfg  r_cfg;
    logic  restart;
    logic  queue_full;
    logic  push;
    t_item push_item;
    logic  pop;
    logic  nonempty;
    t_item head;

    always_comb begin
        restart = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_OBSTACLE_CODE, REG_ROW_WIDTH, REG_ROW_COUNT: restart = 1'b1;
                default: restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obstacle_code <= CHAR_W'(111);
            r_cfg.row_width     <= MAX_COLS_V;
            r_cfg.row_count     <= MAX_ROWS_V;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_OBSTACLE_CODE: r_cfg.obstacle_code <= i_cfg_data[CHAR_W-1:0];
                REG_ROW_WIDTH:     r_cfg.row_width     <= i_cfg_data;
                REG_ROW_COUNT:     r_cfg.row_count     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lesq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cell_char  (i_cell_char),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_item       (push_item)
    );

    lesq_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (push_item),
        .o_full     (queue_full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    lesq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (restart),
        .i_nonempty    (nonempty),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_square_size (o_square_size),
        .o_bottom_row  (o_bottom_row),
        .o_right_col   (o_right_col)
    );

endmodule

// ----- dv/largest_empty_square_scan_tb.sv -----
// testbench for the largest empty square scan: directed maps, config writes, random maps, then a stalled receiver
`timescale 1ns / 100ps

module largest_empty_square_scan_tb;
    import lesq_pkg::*;

    localparam logic [IDX_W-1:0]  REG_UNUSED   = 2'd3;
    localparam logic [CHAR_W-1:0] FREE_CH      = 8'h2E;
    localparam logic [CHAR_W-1:0] BLOCK_CH     = 8'h6F;
    localparam logic [CFG_W-1:0]  RESET_CODE   = 11'd111;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_CELLS = 660;

    typedef struct packed {
        logic [SIZE_W-1:0] side;
        logic [ROW_W-1:0]  bottom_row;
        logic [COL_W-1:0]  right_col;
    } t_square;

    typedef struct packed {
        logic [CFG_W-1:0] code;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] rows;
        logic [63:0]      chars;
        bit               typed;
        t_square          want;
    } t_dir_map;

    // chars: first cell in the low byte
    localparam t_dir_map DIR_MAPS [7] = '{
        '{RESET_CODE, 11'd1, 11'd1, 64'h2E,           1'b1, '{11'd1, 10'd0, 10'd0}},
        '{RESET_CODE, 11'd1, 11'd1, 64'h6F,           1'b1, '{11'd0, 10'd0, 10'd0}},
        '{RESET_CODE, 11'd2, 11'd2, 64'h2E2E2E2E,     1'b1, '{11'd2, 10'd1, 10'd1}},
        '{11'h000,    11'd3, 11'd1, 64'h00FF00,       1'b1, '{11'd1, 10'd0, 10'd1}},
        '{11'h0FF,    11'd0, 11'd2, 64'h00FF,         1'b1, '{11'd1, 10'd1, 10'd0}},
        '{11'h7AB,    11'd2, 11'd2, 64'h020100AB,     1'b1, '{11'd1, 10'd0, 10'd1}},
        '{RESET_CODE, 11'd3, 11'd2, 64'h2E2E2E6F2E2E, 1'b0, '0}
    };

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_ready;
    logic [CHAR_W-1:0] i_cell_char = '0;
    logic              o_valid;
    logic              i_ready     = 1'b0;
    logic [SIZE_W-1:0] o_square_size;
    logic [ROW_W-1:0]  o_bottom_row;
    logic [COL_W-1:0]  o_right_col;
    logic              i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data  = '0;

    largest_empty_square_scan dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cell_char   (i_cell_char),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_square_size (o_square_size),
        .o_bottom_row  (o_bottom_row),
        .o_right_col   (o_right_col),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    logic [CHAR_W-1:0] cfg_code;
    logic [CFG_W-1:0]  cfg_width;
    logic [CFG_W-1:0]  cfg_rows;
    logic [SIZE_W-1:0] line_scores [MAX_COLS];
    logic [SIZE_W-1:0] left_run;
    logic [SIZE_W-1:0] diag_run;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [SIZE_W-1:0] best_side;
    logic [ROW_W-1:0]  best_row;
    logic [COL_W-1:0]  best_col;

    t_square pending_squares [$];
    t_square rx_front;
    int      n_fail   = 0;
    int      n_cycles = 0;
    int      rx_wait  = 0;
    bit      tx_idle  = 1'b1;
    bit      rx_idle  = 1'b1;
    bit      rx_hold_tog  = 1'b0;
    bit      rx_hold_seen = 1'b0;

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int top);
        if (v == '0) begin
            return 1;
        end
        return (int'(v) > top) ? top : int'(v);
    endfunction

    function automatic void restart_scan();
        left_run  = '0;
        diag_run  = '0;
        cur_row   = '0;
        cur_col   = '0;
        best_side = '0;
        best_row  = '0;
        best_col  = '0;
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            REG_OBSTACLE_CODE: cfg_code = data[CHAR_W-1:0];
            REG_ROW_WIDTH:     cfg_width = data;
            REG_ROW_COUNT:     cfg_rows = data;
            default:           return;
        endcase
        restart_scan();
    endfunction

    function automatic void score_cell(input logic [CHAR_W-1:0] ch, output bit done,
                                       output t_square res);
        int w;
        int h;
        int up;
        int score;
        w = clamp_dim(cfg_width, MAX_COLS);
        h = clamp_dim(cfg_rows, MAX_ROWS);
        up = int'(line_scores[cur_col]);
        done = 1'b0;
        res = '0;
        if (ch == cfg_code) begin
            score = 0;
        end else if (cur_row == '0 || cur_col == '0) begin
            score = 1;
        end else begin
            score = up;
            if (int'(left_run) < score) score = int'(left_run);
            if (int'(diag_run) < score) score = int'(diag_run);
            score = score + 1;
        end
        if (score > int'(best_side)) begin
            best_side = SIZE_W'(score);
            best_row  = cur_row;
            best_col  = cur_col;
        end
        diag_run = SIZE_W'(up);
        left_run = SIZE_W'(score);
        line_scores[cur_col] = SIZE_W'(score);
        if (int'(cur_col) + 1 >= w) begin
            cur_col  = '0;
            left_run = '0;
            diag_run = '0;
            if (int'(cur_row) + 1 >= h) begin
                res = '{best_side, best_row, best_col};
                done = 1'b1;
                restart_scan();
            end else begin
                cur_row = cur_row + ROW_W'(1);
            end
        end else begin
            cur_col = cur_col + COL_W'(1);
        end
    endfunction

    task automatic set_map(input logic [CFG_W-1:0] code, input logic [CFG_W-1:0] width,
                           input logic [CFG_W-1:0] rows);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_OBSTACLE_CODE;
        i_cfg_data  <= code;
        apply_reg(REG_OBSTACLE_CODE, code);
        @(posedge i_clk);
        i_cfg_index <= REG_ROW_WIDTH;
        i_cfg_data  <= width;
        apply_reg(REG_ROW_WIDTH, width);
        @(posedge i_clk);
        i_cfg_index <= REG_ROW_COUNT;
        i_cfg_data  <= rows;
        apply_reg(REG_ROW_COUNT, rows);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_cell(input logic [CHAR_W-1:0] ch, input bit typed, input t_square want);
        int      gap;
        bit      done;
        t_square got;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cell_char <= ch;
        do @(posedge i_clk); while (!o_ready);
        score_cell(ch, done, got);
        if (done) begin
            pending_squares.push_back(typed ? want : got);
        end
    endtask

    // density in percent; above 100 blocks every cell
    task automatic send_map(input logic [CHAR_W-1:0] code, input int n_take, input int density);
        logic [CHAR_W-1:0] ch;
        for (int k = 0; k < n_take; k++) begin
            ch = ($urandom_range(0, 99) < density) ? code : CHAR_W'($urandom_range(0, 255));
            send_cell(ch, 1'b0, '0);
        end
    endtask

    task automatic drain_scan();
        i_valid <= 1'b0;
        while (pending_squares.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_squares.size() == 0) begin
                    $error("result with no request pending: size %0d row %0d col %0d",
                           o_square_size, o_bottom_row, o_right_col);
                    n_fail++;
                end else begin
                    rx_front = pending_squares.pop_front();
                    if (o_square_size !== rx_front.side) begin
                        $error("square_size: expected %0d, actual %0d", rx_front.side,
                               o_square_size);
                        n_fail++;
                    end
                    if (o_bottom_row !== rx_front.bottom_row) begin
                        $error("bottom_row: expected %0d, actual %0d", rx_front.bottom_row,
                               o_bottom_row);
                        n_fail++;
                    end
                    if (o_right_col !== rx_front.right_col) begin
                        $error("right_col: expected %0d, actual %0d", rx_front.right_col,
                               o_right_col);
                        n_fail++;
                    end
                end
                rx_wait = rx_idle ? $urandom_range(0, 10) : 0;
            end
            if (rx_hold_tog != rx_hold_seen) begin
                rx_hold_seen = rx_hold_tog;
                rx_wait = HOLD_CYCLES;
            end
            if (rx_wait > 0) begin
                i_ready <= 1'b0;
                rx_wait--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int               n_cells;
        int               rand_cells;
        int               n_maps;
        int               n_take;
        logic [CFG_W-1:0] code;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] rows;
        foreach (line_scores[i]) line_scores[i] = '0;
        cfg_code  = RESET_CODE[CHAR_W-1:0];
        cfg_width = MAX_COLS_V;
        cfg_rows  = MAX_ROWS_V;
        restart_scan();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_MAPS[i]) begin
            set_map(DIR_MAPS[i].code, DIR_MAPS[i].width, DIR_MAPS[i].rows);
            n_cells = clamp_dim(DIR_MAPS[i].width, MAX_COLS)
                    * clamp_dim(DIR_MAPS[i].rows, MAX_ROWS);
            for (int k = 0; k < n_cells; k++) begin
                send_cell(DIR_MAPS[i].chars[8*k +: 8], DIR_MAPS[i].typed, DIR_MAPS[i].want);
            end
            drain_scan();
        end

        // write to the spare index leaves the scan running
        set_map(RESET_CODE, 11'd1, 11'd2);
        send_cell(FREE_CH, 1'b0, '0);
        drain_scan();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_UNUSED;
        i_cfg_data  <= 11'h5A5;
        apply_reg(REG_UNUSED, 11'h5A5);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        send_cell(BLOCK_CH, 1'b0, '0);
        drain_scan();

        // real write drops the partial map
        send_cell(FREE_CH, 1'b0, '0);
        drain_scan();
        set_map(RESET_CODE, 11'd1, 11'd2);
        send_cell(BLOCK_CH, 1'b0, '0);
        send_cell(FREE_CH, 1'b0, '0);
        drain_scan();

        rand_cells = 0;
        while (rand_cells < RANDOM_CELLS) begin
            code  = CFG_W'($urandom_range(0, 2047));
            width = CFG_W'($urandom_range(0, 8));
            rows  = CFG_W'($urandom_range(0, 8));
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            set_map(code, width, rows);
            n_cells = clamp_dim(width, MAX_COLS) * clamp_dim(rows, MAX_ROWS);
            n_maps = $urandom_range(1, 4);
            for (int m = 0; m < n_maps; m++) begin
                n_take = n_cells;
                if (m == n_maps - 1 && n_cells > 1 && $urandom_range(0, 5) == 0) begin
                    n_take = $urandom_range(1, n_cells - 1);
                end
                send_map(code[CHAR_W-1:0], n_take, 35 * $urandom_range(0, 3));
                rand_cells += n_take;
            end
            drain_scan();
        end

        // single-cell maps against a stalled receiver fill the block
        tx_idle = 1'b0;
        set_map(RESET_CODE, 11'd1, 11'd1);
        rx_idle = 1'b0;
        rx_hold_tog = ~rx_hold_tog;
        send_map(RESET_CODE[CHAR_W-1:0], 40, 35);
        drain_scan();

        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lesq_pkg.sv
rtl/core/lesq_front.sv
rtl/core/lesq_queue.sv
rtl/core/lesq_back.sv
rtl/core/largest_empty_square_scan.sv
dv/largest_empty_square_scan_tb.sv
